[design/qse_pkg.sv]
// shared types and constants of the quicksort engine
package qse_pkg;

	localparam int QSE_WIDTH = 32;
	localparam int QSE_DEPTH = 16;

	localparam logic QSE_REG_DESCENDING = 1'b0;

	typedef struct packed {
		logic signed [QSE_WIDTH-1:0] value;
		logic                        last_in;
	} qse_elem_t;

	typedef struct packed {
		logic signed [QSE_WIDTH-1:0] sorted_value;
		logic                        last_out;
		logic                        overflow;
	} qse_result_t;

	typedef struct packed {
		logic load;
		logic init;
		logic pop_rd;
		logic pop_ld;
		logic piv_ld;
		logic part_rd;
		logic part_cmp;
		logic part_wr2;
		logic fin_rd;
		logic fin_cmp;
		logic fin_wr;
		logic push_hi;
		logic out_rd;
		logic out_ld;
		logic out_done;
	} qse_cmd_t;

	typedef struct packed {
		logic cnt_lt2;
		logic sp_zero;
		logic lo_ge_hi;
		logic j_eq_hi;
		logic left;
		logic out_last;
	} qse_sts_t;

endpackage

[design/qse_ram.sv]
// generic single-write, single-read ram with registered read data
module qse_ram #(
	parameter int DW    = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/qse_ctrl.sv]
// sequencer for load, partition, range stack and unload phases
module qse_ctrl import qse_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     elem_valid,
	input  logic     elem_last,
	output logic     elem_ready,
	input  logic     result_ready,
	input  qse_sts_t sts,
	output qse_cmd_t cmd
);

	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_INIT  = 4'd1;
	localparam logic [3:0] S_POP   = 4'd2;
	localparam logic [3:0] S_POPW  = 4'd3;
	localparam logic [3:0] S_PIVW  = 4'd4;
	localparam logic [3:0] S_RD    = 4'd5;
	localparam logic [3:0] S_CMP   = 4'd6;
	localparam logic [3:0] S_WR2   = 4'd7;
	localparam logic [3:0] S_FRD   = 4'd8;
	localparam logic [3:0] S_FCMP  = 4'd9;
	localparam logic [3:0] S_FWR   = 4'd10;
	localparam logic [3:0] S_PUSH2 = 4'd11;
	localparam logic [3:0] S_ORD   = 4'd12;
	localparam logic [3:0] S_OLD   = 4'd13;
	localparam logic [3:0] S_OWAIT = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		elem_ready = 1'b0;
		case (state_q)
			S_LOAD: begin
				elem_ready = 1'b1;
				if (elem_valid) begin
					cmd.load = 1'b1;
					if (elem_last) begin
						state_d = S_INIT;
					end
				end
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = sts.cnt_lt2 ? S_ORD : S_POP;
			end
			S_POP: begin
				if (sts.sp_zero) begin
					state_d = S_ORD;
				end else begin
					cmd.pop_rd = 1'b1;
					state_d    = S_POPW;
				end
			end
			S_POPW: begin
				cmd.pop_ld = 1'b1;
				state_d    = sts.lo_ge_hi ? S_POP : S_PIVW;
			end
			S_PIVW: begin
				cmd.piv_ld = 1'b1;
				state_d    = S_RD;
			end
			S_RD: begin
				if (sts.j_eq_hi) begin
					state_d = S_FRD;
				end else begin
					cmd.part_rd = 1'b1;
					state_d     = S_CMP;
				end
			end
			S_CMP: begin
				cmd.part_cmp = 1'b1;
				state_d      = sts.left ? S_WR2 : S_RD;
			end
			S_WR2: begin
				cmd.part_wr2 = 1'b1;
				state_d      = S_RD;
			end
			S_FRD: begin
				cmd.fin_rd = 1'b1;
				state_d    = S_FCMP;
			end
			S_FCMP: begin
				cmd.fin_cmp = 1'b1;
				state_d     = S_FWR;
			end
			S_FWR: begin
				cmd.fin_wr = 1'b1;
				state_d    = S_PUSH2;
			end
			S_PUSH2: begin
				cmd.push_hi = 1'b1;
				state_d     = S_POP;
			end
			S_ORD: begin
				cmd.out_rd = 1'b1;
				state_d    = S_OLD;
			end
			S_OLD: begin
				cmd.out_ld = 1'b1;
				state_d    = S_OWAIT;
			end
			S_OWAIT: begin
				if (result_ready) begin
					cmd.out_done = 1'b1;
					state_d      = sts.out_last ? S_LOAD : S_ORD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/qse_dpath.sv]
// element store, range stack, index counters, compare and result register
module qse_dpath import qse_pkg::*; #(
	parameter int DEPTH = QSE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  qse_cmd_t    cmd,
	input  qse_elem_t   elem_data,
	input  logic        descending,
	output qse_sts_t    sts,
	output logic        result_valid,
	output qse_result_t result_data
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]        count_q;
	logic                 dropped_q;
	logic [CW-1:0]        sp_q;
	logic [IW-1:0]        lo_q;
	logic [IW-1:0]        hi_q;
	logic [IW-1:0]        j_q;
	logic [IW-1:0]        k_q;
	logic [IW-1:0]        oidx_q;
	logic [QSE_WIDTH-1:0] pivot_q;
	logic [QSE_WIDTH-1:0] tmp_q;
	logic                 out_valid_q;
	qse_result_t          out_q;

	logic                 st_we;
	logic [IW-1:0]        st_waddr;
	logic [QSE_WIDTH-1:0] st_wdata;
	logic [IW-1:0]        st_raddr_a;
	logic [IW-1:0]        st_raddr_b;
	logic [QSE_WIDTH-1:0] st_rdata_a;
	logic [QSE_WIDTH-1:0] st_rdata_b;

	logic                 rs_we;
	logic [IW-1:0]        rs_waddr;
	logic [2*IW-1:0]      rs_wdata;
	logic [IW-1:0]        rs_raddr;
	logic [2*IW-1:0]      rs_rdata;

	logic                 room;
	logic                 sp_room;
	logic                 left;
	logic                 push_lo_ok;
	logic                 push_hi_ok;
	logic [CW-1:0]        count_m1;
	logic [IW:0]          k_ext;
	logic [IW:0]          lo_ext;
	logic [IW:0]          hi_ext;

	assign room     = count_q < CW'(DEPTH);
	assign sp_room  = sp_q < CW'(DEPTH);
	assign count_m1 = count_q - CW'(1);
	assign k_ext    = {1'b0, k_q};
	assign lo_ext   = {1'b0, lo_q};
	assign hi_ext   = {1'b0, hi_q};

	assign left = descending ? ($signed(st_rdata_a) > $signed(pivot_q))
	                         : ($signed(st_rdata_a) <= $signed(pivot_q));

	assign push_lo_ok = (k_ext > lo_ext + (IW+1)'(1)) && sp_room;
	assign push_hi_ok = (k_ext + (IW+1)'(1) < hi_ext) && sp_room;

	// store write and read address selection
	always_comb begin
		st_we      = 1'b0;
		st_waddr   = k_q;
		st_wdata   = st_rdata_a;
		st_raddr_a = j_q;
		st_raddr_b = k_q;
		if (cmd.load) begin
			st_we    = room;
			st_waddr = count_q[IW-1:0];
			st_wdata = elem_data.value;
		end else if (cmd.part_cmp) begin
			st_we = left;
		end else if (cmd.part_wr2) begin
			st_we    = 1'b1;
			st_waddr = j_q;
			st_wdata = tmp_q;
		end else if (cmd.fin_cmp) begin
			st_we    = 1'b1;
			st_wdata = st_rdata_b;
		end else if (cmd.fin_wr) begin
			st_we    = 1'b1;
			st_waddr = hi_q;
			st_wdata = tmp_q;
		end
		if (cmd.pop_ld) begin
			st_raddr_a = rs_rdata[IW-1:0];
		end else if (cmd.fin_rd) begin
			st_raddr_a = k_q;
			st_raddr_b = hi_q;
		end else if (cmd.out_rd) begin
			st_raddr_a = oidx_q;
		end
	end

	// range stack push and pop
	always_comb begin
		rs_we    = 1'b0;
		rs_waddr = sp_q[IW-1:0];
		rs_wdata = {lo_q, k_q - IW'(1)};
		rs_raddr = sp_q[IW-1:0] - IW'(1);
		if (cmd.init) begin
			rs_we    = 1'b1;
			rs_waddr = '0;
			rs_wdata = {IW'(0), count_m1[IW-1:0]};
		end else if (cmd.fin_wr) begin
			rs_we = push_lo_ok;
		end else if (cmd.push_hi) begin
			rs_we    = push_hi_ok;
			rs_wdata = {k_q + IW'(1), hi_q};
		end
	end

	qse_ram #(.DW(QSE_WIDTH), .DEPTH(DEPTH)) u_store_a (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr_a),
		.rdata (st_rdata_a)
	);

	qse_ram #(.DW(QSE_WIDTH), .DEPTH(DEPTH)) u_store_b (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr_b),
		.rdata (st_rdata_b)
	);

	qse_ram #(.DW(2*IW), .DEPTH(DEPTH)) u_stack (
		.clk   (clk),
		.we    (rs_we),
		.waddr (rs_waddr),
		.wdata (rs_wdata),
		.raddr (rs_raddr),
		.rdata (rs_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dropped_q   <= 1'b0;
			sp_q        <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			j_q         <= '0;
			k_q         <= '0;
			oidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (room) begin
					count_q <= count_q + CW'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (cmd.init) begin
				sp_q   <= CW'(1);
				oidx_q <= '0;
			end
			if (cmd.pop_rd) begin
				sp_q <= sp_q - CW'(1);
			end
			if (cmd.pop_ld) begin
				lo_q <= rs_rdata[2*IW-1:IW];
				hi_q <= rs_rdata[IW-1:0];
				j_q  <= rs_rdata[2*IW-1:IW];
				k_q  <= rs_rdata[2*IW-1:IW];
			end
			if (cmd.part_cmp && !left) begin
				j_q <= j_q + IW'(1);
			end
			if (cmd.part_wr2) begin
				j_q <= j_q + IW'(1);
				k_q <= k_q + IW'(1);
			end
			if ((cmd.fin_wr && push_lo_ok) || (cmd.push_hi && push_hi_ok)) begin
				sp_q <= sp_q + CW'(1);
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end
			if (cmd.out_done) begin
				out_valid_q <= 1'b0;
				oidx_q      <= oidx_q + IW'(1);
				if (out_q.last_out) begin
					count_q   <= '0;
					dropped_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.piv_ld) begin
			pivot_q <= st_rdata_a;
		end
		if (cmd.part_cmp) begin
			tmp_q <= st_rdata_b;
		end
		if (cmd.fin_cmp) begin
			tmp_q <= st_rdata_a;
		end
		if (cmd.out_ld) begin
			out_q.sorted_value <= st_rdata_a;
			out_q.last_out     <= (CW'(oidx_q) == count_m1);
			out_q.overflow     <= dropped_q;
		end
	end

	assign sts.cnt_lt2  = count_q < CW'(2);
	assign sts.sp_zero  = (sp_q == '0);
	assign sts.lo_ge_hi = rs_rdata[2*IW-1:IW] >= rs_rdata[IW-1:0];
	assign sts.j_eq_hi  = (j_q == hi_q);
	assign sts.left     = left;
	assign sts.out_last = out_q.last_out;

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count beyond store depth");

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CW'(DEPTH))
		else $error("range stack pointer beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_rd |-> sp_q != '0)
		else $error("pop from empty range stack");

	a_k_le_j: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.part_rd |-> k_q <= j_q)
		else $error("partition boundary passed scan index");

	a_no_load_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !cmd.load)
		else $error("load while a result is pending");

endmodule

[design/quicksort_engine.sv]
// top level of the quicksort engine: request channels and register port
//
//  channel   direction  handshake                   payload
//  elem      in         elem_valid / elem_ready     qse_elem_t (value, last_in)
//  result    out        result_valid / result_ready qse_result_t (sorted_value, last_out, overflow)
//  config    in         psel / penable / pready     descending at byte address 0
//
//  one request is loaded per cycle while the engine is in its load phase
//  sorting reads and compares each element in separate states, with an extra write state
//  per swap, set by the registered store read and its single write port; each partitioned
//  range adds pop, pivot load, final swap and push states, plus the first and final stack checks
//  each result passes through read, load and wait states and holds in the wait state until result_ready
//  no new requests are taken while a set is being sorted or unloaded
//  reset clears counts, flags, stack pointer and the descending bit
module quicksort_engine import qse_pkg::*; #(
	parameter int DEPTH = QSE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        elem_valid,
	output logic        elem_ready,
	input  qse_elem_t   elem_data,
	output logic        result_valid,
	input  logic        result_ready,
	output qse_result_t result_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic     descending_q;
	qse_cmd_t cmd;
	qse_sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == QSE_REG_DESCENDING) begin
			descending_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == QSE_REG_DESCENDING) ? {31'b0, descending_q} : 32'b0;

	qse_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.elem_valid   (elem_valid),
		.elem_last    (elem_data.last_in),
		.elem_ready   (elem_ready),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	qse_dpath #(.DEPTH(DEPTH)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.elem_data    (elem_data),
		.descending   (descending_q),
		.sts          (sts),
		.result_valid (result_valid),
		.result_data  (result_data)
	);

endmodule

[verif/quicksort_engine_test.sv]
// testbench for quicksort_engine: directed and random sets checked against a partition-sort predictor
`timescale 1ns / 1ps

module quicksort_engine_test;
	import qse_pkg::*;

	localparam logic [2:0] ADDR_DESCENDING = {QSE_REG_DESCENDING, 2'b00};
	localparam logic [2:0] ADDR_SPARE = 3'd4;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_ITEMS = 400;

	typedef enum logic {ROW_ELEM, ROW_CFG} row_kind_e;
	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW} rx_mode_e;

	typedef struct {
		row_kind_e   kind;
		qse_elem_t   elem;
		logic [2:0]  addr;
		logic [31:0] data;
		bit          typed;
		qse_result_t want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        elem_valid = 1'b0;
	logic        elem_ready;
	qse_elem_t   elem_data = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	qse_result_t result_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// predictor state
	logic signed [QSE_WIDTH-1:0] set_store [QSE_DEPTH];
	int unsigned held = 0;
	bit          lost = 1'b0;
	bit          desc_mode = 1'b0;
	qse_result_t sorted_buf [QSE_DEPTH];
	qse_result_t sorted_due [$];

	int       errors = 0;
	int       burst_left = 0;
	bit       valid_held = 1'b0;
	logic [7:0] rx_cycle = '0;
	rx_mode_e rx_mode = RX_FREE;

	quicksort_engine u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.elem_valid   (elem_valid),
		.elem_ready   (elem_ready),
		.elem_data    (elem_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("quicksort_engine_test failed");
		$finish;
	end

	// stores one request; on the last one sorts the set and returns the result count
	function automatic int absorb_elem(input qse_elem_t e);
		int lo_stack [$];
		int hi_stack [$];
		int lo, hi, j, k, n;
		logic signed [QSE_WIDTH-1:0] pivot, tmp;
		bit left;
		if (held < QSE_DEPTH) begin
			set_store[held] = e.value;
			held++;
		end else begin
			lost = 1'b1;
		end
		if (!e.last_in)
			return 0;
		if (held >= 2) begin
			lo_stack.push_back(0);
			hi_stack.push_back(held - 1);
		end
		while (lo_stack.size() != 0) begin
			lo = lo_stack.pop_back();
			hi = hi_stack.pop_back();
			if (lo >= hi)
				continue;
			pivot = set_store[hi];
			k = lo;
			for (j = lo; j < hi; j++) begin
				left = desc_mode ? (set_store[j] > pivot) : (set_store[j] <= pivot);
				if (left) begin
					tmp = set_store[k];
					set_store[k] = set_store[j];
					set_store[j] = tmp;
					k++;
				end
			end
			tmp = set_store[k];
			set_store[k] = set_store[hi];
			set_store[hi] = tmp;
			if (k > lo + 1 && lo_stack.size() < QSE_DEPTH) begin
				lo_stack.push_back(lo);
				hi_stack.push_back(k - 1);
			end
			if (k + 1 < hi && lo_stack.size() < QSE_DEPTH) begin
				lo_stack.push_back(k + 1);
				hi_stack.push_back(hi);
			end
		end
		n = held;
		for (j = 0; j < n; j++) begin
			sorted_buf[j].sorted_value = set_store[j];
			sorted_buf[j].last_out = (j == n - 1);
			sorted_buf[j].overflow = lost;
		end
		held = 0;
		lost = 1'b0;
		return n;
	endfunction

	function automatic row_t elem_row(input logic signed [QSE_WIDTH-1:0] v, input logic last);
		row_t r;
		r = '{kind: ROW_ELEM, elem: '{value: v, last_in: last}, addr: '0, data: '0,
			typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic row_t cfg_row(input logic [2:0] addr, input logic [31:0] data);
		row_t r;
		r = '{kind: ROW_CFG, elem: '0, addr: addr, data: data, typed: 1'b0, want: '0};
		return r;
	endfunction

	task automatic put_elem(input qse_elem_t e, input bit typed, input qse_result_t want);
		int n;
		int gap;
		elem_data <= e;
		if (!valid_held) begin
			elem_valid <= 1'b1;
			valid_held = 1'b1;
		end
		do @(posedge clk); while (!elem_ready);
		n = absorb_elem(e);
		if (typed) begin
			sorted_due.push_back(want);
		end else begin
			for (int i = 0; i < n; i++)
				sorted_due.push_back(sorted_buf[i]);
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				elem_valid <= 1'b0;
				valid_held = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// let every expected result arrive and the engine settle back into loading
	task automatic drain();
		if (valid_held) begin
			elem_valid <= 1'b0;
			valid_held = 1'b0;
		end
		while (sorted_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr[2] == QSE_REG_DESCENDING)
			desc_mode = data[0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 8'd1;
		if (rx_cycle == 8'd0)
			rx_mode <= rx_mode_e'($urandom_range(0, 2));
		case (rx_mode)
			RX_FREE: result_ready <= 1'b1;
			RX_COIN: result_ready <= 1'($urandom_range(0, 1));
			default: result_ready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	always @(posedge clk) begin
		qse_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (sorted_due.size() == 0) begin
				$display("%0t: unexpected result expected none actual value %h last %b ovf %b",
					$time, result_data.sorted_value, result_data.last_out,
					result_data.overflow);
				errors++;
			end else begin
				want = sorted_due.pop_front();
				if (result_data !== want) begin
					$display("%0t: result mismatch expected value %h last %b ovf %b actual value %h last %b ovf %b",
						$time, want.sorted_value, want.last_out, want.overflow,
						result_data.sorted_value, result_data.last_out, result_data.overflow);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t plan [$];
		row_t r;
		int sent;
		int set_len;
		int mix;
		logic signed [QSE_WIDTH-1:0] v;

		// single request right after reset
		r = elem_row(32'sh7FFF_FFFF, 1'b1);
		r.typed = 1'b1;
		r.want = '{sorted_value: 32'sh7FFF_FFFF, last_out: 1'b1, overflow: 1'b0};
		plan.push_back(r);
		// extremes and equal keys, ascending
		plan.push_back(elem_row(32'sh8000_0000, 1'b0));
		plan.push_back(elem_row(32'sh0000_0000, 1'b0));
		plan.push_back(elem_row(-32'sd1, 1'b0));
		plan.push_back(elem_row(32'sh0000_0000, 1'b1));
		plan.push_back(cfg_row(ADDR_DESCENDING, 32'd1));
		plan.push_back(elem_row(32'sd7, 1'b0));
		plan.push_back(elem_row(32'sh8000_0000, 1'b0));
		plan.push_back(elem_row(32'sh7FFF_FFFF, 1'b1));
		// write to an unused index leaves the order alone
		plan.push_back(cfg_row(ADDR_SPARE, 32'd0));
		// only bit 0 counts
		plan.push_back(cfg_row(ADDR_DESCENDING, 32'hFFFF_FFFE));
		// store full, the request marked last is dropped too
		for (int i = 0; i <= QSE_DEPTH; i++)
			plan.push_back(elem_row(32'sh9E37_79B9 * (i + 1), i == QSE_DEPTH));
		r = elem_row(32'sh8000_0000, 1'b1);
		r.typed = 1'b1;
		r.want = '{sorted_value: 32'sh8000_0000, last_out: 1'b1, overflow: 1'b0};
		plan.push_back(r);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain();
				write_reg(plan[i].addr, plan[i].data);
			end else begin
				put_elem(plan[i].elem, plan[i].typed, plan[i].want);
			end
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 5) == 0) begin
				drain();
				write_reg(($urandom_range(0, 7) == 0) ? ADDR_SPARE : ADDR_DESCENDING, $urandom());
			end
			set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(QSE_DEPTH + 1, QSE_DEPTH + 5)
				: $urandom_range(1, QSE_DEPTH);
			mix = $urandom_range(0, 2);
			for (int i = 0; i < set_len; i++) begin
				case (mix)
					0: v = $urandom();
					1: v = 32'($urandom_range(0, 6)) - 32'sd3;
					default: begin
						case ($urandom_range(0, 4))
							0: v = 32'sh8000_0000;
							1: v = 32'sh7FFF_FFFF;
							2: v = 32'sh0000_0000;
							3: v = -32'sd1;
							default: v = $urandom();
						endcase
					end
				endcase
				put_elem('{value: v, last_in: (i == set_len - 1)}, 1'b0, '0);
				sent++;
			end
		end

		drain();
		if (errors == 0)
			$display("quicksort_engine_test passed");
		else
			$display("quicksort_engine_test failed");
		$finish;
	end

endmodule

[files.f]
design/qse_pkg.sv
design/qse_ram.sv
design/qse_ctrl.sv
design/qse_dpath.sv
design/quicksort_engine.sv
verif/quicksort_engine_test.sv
